/* rtl/core/tlfrq_pkg.sv */
// Package for the three-level feedback ready queue.
// Holds payload structs, codes, controller types and compare functions.
// No dependencies.
package tlfrq_pkg;

    localparam int TABLE_SLOTS_DEF = 32;

    localparam logic [15:0] AGING_THRESHOLD_RST  = 16'd200;
    localparam logic [15:0] WAIT_STEP_RST        = 16'd100;
    localparam logic [7:0]  PRIORITY_STEP_RST    = 8'd10;
    localparam logic [7:0]  PRIORITY_CEILING_RST = 8'd149;
    localparam logic [7:0]  LEVEL_ONE_FLOOR_RST  = 8'd100;
    localparam logic [7:0]  LEVEL_TWO_FLOOR_RST  = 8'd50;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_AGING_THRESHOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAIT_STEP        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIORITY_STEP    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRIORITY_CEILING = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_ONE_FLOOR  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_TWO_FLOOR  = 3'd5;

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_PICK    = 2'd1;
    localparam logic [1:0] ACT_AGE     = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic [1:0] LVL_NONE  = 2'd0;
    localparam logic [1:0] LVL_ONE   = 2'd1;
    localparam logic [1:0] LVL_TWO   = 2'd2;
    localparam logic [1:0] LVL_THREE = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] thread_id;
        logic [7:0]  priority_req;
        logic [19:0] remaining_burst;
        logic [19:0] current_burst;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chosen_id;
        logic [1:0]  chosen_level;
        logic [7:0]  chosen_priority;
        logic [19:0] chosen_burst;
        logic        preempt;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ,
        S_PICK,
        S_PICK_END,
        S_AGE,
        S_PROMO,
        S_PROMO_END,
        S_DONE
    } fsm_state_t;

    typedef struct packed {
        logic capture;
        logic idx_inc;
        logic idx_clr;
        logic enq_step;
        logic pick_step;
        logic pick_end;
        logic age_step;
        logic promo_step;
        logic promo_end;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       idx_last;
        logic       slot_free;
        logic       promo_found;
        logic       src_is_two;
        logic       out_free;
    } dp_status_t;

    function automatic logic [1:0] level_of(input logic [7:0] prio,
                                            input logic [7:0] floor_one,
                                            input logic [7:0] floor_two);
        logic [1:0] lv;
        if (prio >= floor_one)
            lv = LVL_ONE;
        else if (prio >= floor_two)
            lv = LVL_TWO;
        else
            lv = LVL_THREE;
        return lv;
    endfunction

    // True if candidate a goes ahead of b within level lv; a has the higher slot index.
    function automatic logic ahead(input logic [1:0]  lv,
                                   input logic [19:0] a_burst,
                                   input logic [15:0] a_thread,
                                   input logic [15:0] a_age,
                                   input logic [19:0] b_burst,
                                   input logic [15:0] b_thread,
                                   input logic [15:0] b_age);
        logic res;
        if (lv == LVL_ONE && a_burst != b_burst)
            res = a_burst < b_burst;
        else if (lv == LVL_TWO && a_thread != b_thread)
            res = a_thread < b_thread;
        else
            res = a_age > b_age;
        return res;
    endfunction

endpackage

/* rtl/core/tlfrq_ctrl.sv */
// Controller state machine of the ready queue.
// Sequences slot scans and issues commands to tlfrq_datapath; uses tlfrq_pkg.
module tlfrq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tlfrq_pkg::dp_status_t st,
    output tlfrq_pkg::ctl_cmd_t   cmd
);
    import tlfrq_pkg::*;

    fsm_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    unique case (st.action)
                        ACT_ENQUEUE: state_next = S_ENQ;
                        ACT_PICK:    state_next = S_PICK;
                        ACT_AGE:     state_next = S_AGE;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_ENQ:
            begin
                cmd.enq_step = 1'b1;
                if (st.slot_free || st.idx_last)
                    state_next = S_DONE;
                else
                    cmd.idx_inc = 1'b1;
            end
            S_PICK:
            begin
                cmd.pick_step = 1'b1;
                if (st.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_PICK_END;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_PICK_END:
            begin
                cmd.pick_end = 1'b1;
                state_next   = S_DONE;
            end
            S_AGE:
            begin
                cmd.age_step = 1'b1;
                if (st.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_PROMO;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_PROMO:
            begin
                cmd.promo_step = 1'b1;
                if (st.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_PROMO_END;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_PROMO_END:
            begin
                cmd.promo_end = 1'b1;
                if (st.promo_found || st.src_is_two)
                    state_next = S_PROMO;
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/tlfrq_datapath.sv */
// Datapath of the ready queue: slot table, scan index, best trackers, results.
// Driven by tlfrq_ctrl commands; uses tlfrq_pkg.
module tlfrq_datapath #(
    parameter int TABLE_SLOTS = tlfrq_pkg::TABLE_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlfrq_pkg::in_item_t               in_data,
    output tlfrq_pkg::out_item_t              out_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              cfg_we,
    input  logic [tlfrq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                       cfg_wdata,
    input  tlfrq_pkg::ctl_cmd_t               cmd,
    output tlfrq_pkg::dp_status_t             st
);
    import tlfrq_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);

    logic [15:0] thr_reg, wstep_reg;
    logic [7:0]  pstep_reg, ceil_reg, floor1_reg, floor2_reg;

    logic [15:0] s_thread [TABLE_SLOTS];
    logic [7:0]  s_prio   [TABLE_SLOTS];
    logic [19:0] s_burst  [TABLE_SLOTS];
    logic [15:0] s_wait   [TABLE_SLOTS];
    logic [1:0]  s_level  [TABLE_SLOTS];
    logic [15:0] s_arr    [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0] valid_reg, pend_reg;
    logic [15:0] ctr_reg, base_reg;
    logic [IW-1:0] idx_reg;
    logic [1:0] src_reg;
    in_item_t item_reg;

    logic [3:0]    bvalid_reg;
    logic [IW-1:0] bidx_reg    [4];
    logic [15:0]   bthread_reg [4];
    logic [19:0]   bburst_reg  [4];
    logic [7:0]    bprio_reg   [4];
    logic [15:0]   barr_reg    [4];

    logic          pvalid_reg;
    logic [IW-1:0] pidx_reg;
    logic [15:0]   pthread_reg;
    logic [19:0]   pburst_reg;
    logic [15:0]   parr_reg;

    out_item_t res_reg, out_data_reg;
    logic      out_valid_reg;

    logic [15:0] rd_thread, rd_wait, rd_arr, rd_age;
    logic [7:0]  rd_prio;
    logic [19:0] rd_burst;
    logic [1:0]  rd_level, new_lvl, pick_lv;
    logic        rd_valid, pick_upd, promo_cand, promo_upd, pick_found;
    logic [16:0] w_sum;
    logic [15:0] w_new;
    logic [8:0]  p_sum;
    logic [7:0]  p_new;
    logic        aged, pend_new, enq_wr;

    assign rd_thread = s_thread[idx_reg];
    assign rd_prio   = s_prio[idx_reg];
    assign rd_burst  = s_burst[idx_reg];
    assign rd_wait   = s_wait[idx_reg];
    assign rd_level  = s_level[idx_reg];
    assign rd_arr    = s_arr[idx_reg];
    assign rd_valid  = valid_reg[idx_reg];
    assign rd_age    = base_reg - rd_arr;

    assign new_lvl = level_of(item_reg.priority_req, floor1_reg, floor2_reg);
    assign enq_wr  = cmd.enq_step && !rd_valid;

    assign pick_upd = rd_valid && (!bvalid_reg[rd_level] ||
        ahead(rd_level, rd_burst, rd_thread, rd_age, bburst_reg[rd_level],
              bthread_reg[rd_level], base_reg - barr_reg[rd_level]));

    assign promo_cand = rd_valid && pend_reg[idx_reg] && rd_level == src_reg;
    assign promo_upd  = promo_cand && (!pvalid_reg ||
        ahead(src_reg, rd_burst, rd_thread, rd_age, pburst_reg, pthread_reg,
              base_reg - parr_reg));

    always_comb
    begin
        w_sum = {1'b0, rd_wait} + {1'b0, wstep_reg};
        w_new = w_sum[16] ? 16'hFFFF : w_sum[15:0];
        aged  = w_new > thr_reg;
        p_sum = {1'b0, rd_prio} + {1'b0, pstep_reg};
        if (p_sum > {1'b0, ceil_reg})
            p_sum = {1'b0, ceil_reg};
        if (p_sum < {1'b0, rd_prio})
            p_sum = {1'b0, rd_prio};
        p_new = p_sum[7:0];
        pend_new = rd_valid && aged &&
            ((rd_level == LVL_TWO && p_new >= floor1_reg) ||
             (rd_level == LVL_THREE && p_new >= floor2_reg));
    end

    always_comb
    begin
        pick_found = 1'b1;
        priority if (bvalid_reg[LVL_ONE])
            pick_lv = LVL_ONE;
        else if (bvalid_reg[LVL_TWO])
            pick_lv = LVL_TWO;
        else if (bvalid_reg[LVL_THREE])
            pick_lv = LVL_THREE;
        else
        begin
            pick_lv    = LVL_NONE;
            pick_found = 1'b0;
        end
    end

    assign st.action      = in_data.action;
    assign st.idx_last    = idx_reg == IW'(TABLE_SLOTS - 1);
    assign st.slot_free   = !rd_valid;
    assign st.promo_found = pvalid_reg;
    assign st.src_is_two  = src_reg == LVL_TWO;
    assign st.out_free    = !out_valid_reg || out_ready;

    assign out_data  = out_data_reg;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= AGING_THRESHOLD_RST;
            wstep_reg     <= WAIT_STEP_RST;
            pstep_reg     <= PRIORITY_STEP_RST;
            ceil_reg      <= PRIORITY_CEILING_RST;
            floor1_reg    <= LEVEL_ONE_FLOOR_RST;
            floor2_reg    <= LEVEL_TWO_FLOOR_RST;
            valid_reg     <= '0;
            pend_reg      <= '0;
            ctr_reg       <= '0;
            idx_reg       <= '0;
            src_reg       <= LVL_TWO;
            bvalid_reg    <= '0;
            pvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_AGING_THRESHOLD:  thr_reg    <= cfg_wdata;
                    CFG_WAIT_STEP:        wstep_reg  <= cfg_wdata;
                    CFG_PRIORITY_STEP:    pstep_reg  <= cfg_wdata[7:0];
                    CFG_PRIORITY_CEILING: ceil_reg   <= cfg_wdata[7:0];
                    CFG_LEVEL_ONE_FLOOR:  floor1_reg <= cfg_wdata[7:0];
                    CFG_LEVEL_TWO_FLOOR:  floor2_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (cmd.capture || cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.capture)
            begin
                pend_reg   <= '0;
                bvalid_reg <= '0;
                pvalid_reg <= 1'b0;
                src_reg    <= LVL_TWO;
            end
            if (enq_wr)
            begin
                valid_reg[idx_reg] <= 1'b1;
                ctr_reg            <= ctr_reg + 16'd1;
            end
            if (cmd.pick_step && pick_upd)
                bvalid_reg[rd_level] <= 1'b1;
            if (cmd.pick_end && pick_found)
                valid_reg[bidx_reg[pick_lv]] <= 1'b0;
            if (cmd.age_step)
                pend_reg[idx_reg] <= pend_new;
            if (cmd.promo_step && promo_upd)
                pvalid_reg <= 1'b1;
            if (cmd.promo_end)
            begin
                if (pvalid_reg)
                begin
                    pend_reg[pidx_reg] <= 1'b0;
                    ctr_reg            <= ctr_reg + 16'd1;
                    pvalid_reg         <= 1'b0;
                end
                else if (src_reg == LVL_TWO)
                    src_reg <= LVL_THREE;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
            base_reg <= ctr_reg;
            res_reg  <= '0;
        end
        if (enq_wr)
        begin
            s_thread[idx_reg] <= item_reg.thread_id;
            s_prio[idx_reg]   <= item_reg.priority_req;
            s_burst[idx_reg]  <= item_reg.remaining_burst;
            s_wait[idx_reg]   <= '0;
            s_level[idx_reg]  <= new_lvl;
            s_arr[idx_reg]    <= ctr_reg;
            res_reg.chosen_level <= new_lvl;
            res_reg.preempt <= new_lvl == LVL_ONE &&
                item_reg.current_burst > item_reg.remaining_burst;
        end
        else if (cmd.enq_step && st.idx_last)
            res_reg.status <= STAT_FULL;
        if (cmd.pick_step && pick_upd)
        begin
            bidx_reg[rd_level]    <= idx_reg;
            bthread_reg[rd_level] <= rd_thread;
            bburst_reg[rd_level]  <= rd_burst;
            bprio_reg[rd_level]   <= rd_prio;
            barr_reg[rd_level]    <= rd_arr;
        end
        if (cmd.pick_end)
        begin
            if (pick_found)
            begin
                res_reg.chosen_id       <= bthread_reg[pick_lv];
                res_reg.chosen_priority <= bprio_reg[pick_lv];
                res_reg.chosen_burst    <= bburst_reg[pick_lv];
                res_reg.chosen_level    <= pick_lv;
            end
            else
                res_reg.status <= STAT_EMPTY;
        end
        if (cmd.age_step && rd_valid)
        begin
            s_wait[idx_reg] <= w_new;
            if (aged)
                s_prio[idx_reg] <= p_new;
        end
        if (cmd.promo_step && promo_upd)
        begin
            pidx_reg    <= idx_reg;
            pthread_reg <= rd_thread;
            pburst_reg  <= rd_burst;
            parr_reg    <= rd_arr;
        end
        if (cmd.promo_end && pvalid_reg)
        begin
            s_level[pidx_reg] <= src_reg - 2'd1;
            s_wait[pidx_reg]  <= '0;
            s_arr[pidx_reg]   <= ctr_reg;
            if (src_reg == LVL_TWO && item_reg.current_burst > pburst_reg)
                res_reg.preempt <= 1'b1;
        end
        if (cmd.load_out)
            out_data_reg <= res_reg;
    end

    a_capture_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> pend_reg == '0 && !pvalid_reg && bvalid_reg == '0)
        else $error("capture did not clear scan state");

    a_enq_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        enq_wr |=> ctr_reg == $past(ctr_reg) + 16'd1)
        else $error("enqueue did not advance arrival counter");

    a_promo_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.promo_end && pvalid_reg |=> !pend_reg[$past(pidx_reg)])
        else $error("promoted slot still pending");

endmodule

/* rtl/core/three_level_feedback_ready_queue.sv */
// Top level of the three-level feedback ready queue with aging.
// Scans one slot per cycle: enqueue stops at the first free slot; pick and age tick scan
// every slot; an age tick then repeats promotion scans while pending entries remain.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: asynchronous active low; clears slot valid bits, arrival counter and registers
// to defaults. Instantiates tlfrq_ctrl and tlfrq_datapath; uses tlfrq_pkg.
module three_level_feedback_ready_queue #(
    parameter int TABLE_SLOTS = tlfrq_pkg::TABLE_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  tlfrq_pkg::in_item_t               in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output tlfrq_pkg::out_item_t              out_data,
    input  logic                              cfg_we,
    input  logic [tlfrq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                       cfg_wdata
);
    import tlfrq_pkg::*;

    ctl_cmd_t   cmd;
    dp_status_t st;

    tlfrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    tlfrq_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
